// ===== rtl/ptlb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptlb_pkg
// Types, class codes and lookup tables shared by the pair table line breaker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptlb_pkg;

   localparam int unsigned CodePointWidth = 21;
   localparam int unsigned ClassWidth     = 6;
   localparam int unsigned RawClasses     = 36;
   localparam int unsigned TableClasses   = 26;

   typedef logic [CodePointWidth-1:0] code_point_type;
   typedef logic [ClassWidth-1:0]     class_type;
   typedef logic [4:0]                table_index_type;

   localparam class_type CLS_AL = 6'd11;
   localparam class_type CLS_WJ = 6'd20;
   localparam class_type CLS_BK = 6'd26;
   localparam class_type CLS_SP = 6'd31;

   localparam code_point_type CP_LINE_FEED      = 21'h00000A;
   localparam code_point_type CP_LINE_SEPARATOR = 21'h002028;
   localparam code_point_type CP_PARA_SEPARATOR = 21'h002029;

   typedef enum logic [2:0] {
      ACT_D,
      ACT_I,
      ACT_P,
      ACT_C,
      ACT_X
   } action_type;

   typedef struct packed {
      code_point_type code_point;
      logic [5:0]     break_type;
      logic           first_of_text;
   } req_item_type;

   typedef struct packed {
      logic      break_before;
      logic      forced;
      class_type char_class;
   } rsp_item_type;

   // Raw property to reduced class. Several raw properties fold into AL.
   localparam class_type REDUCED_CLASS [RawClasses] = '{
      6'd26, 6'd11, 6'd11, 6'd19, 6'd11, 6'd18, 6'd13, 6'd3,  6'd11,
      6'd31, 6'd15, 6'd16, 6'd17, 6'd14, 6'd4,  6'd0,  6'd1,  6'd2,
      6'd5,  6'd12, 6'd10, 6'd7,  6'd6,  6'd11, 6'd8,  6'd9,  6'd11,
      6'd11, 6'd11, 6'd11, 6'd20, 6'd23, 6'd24, 6'd25, 6'd21, 6'd22
   };

   // Rows are the base class, columns the class of the new character.
   localparam action_type PAIR_TABLE [TableClasses][TableClasses] = '{
      '{ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P,
        ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_P, ACT_X, ACT_P, ACT_P, ACT_P, ACT_P,
        ACT_P, ACT_P},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_P, ACT_I, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_P, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_I, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_P, ACT_C, ACT_P, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I},
      '{ACT_I, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_I, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_P, ACT_C, ACT_P, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_I,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_I, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_I,
        ACT_I, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I},
      '{ACT_I, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_I,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_I, ACT_I, ACT_I, ACT_I,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_I,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_D, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_D, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_I, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_I, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_P, ACT_C, ACT_P, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D, ACT_I, ACT_I, ACT_D, ACT_P, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D, ACT_P, ACT_D, ACT_D, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_D, ACT_I, ACT_I,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_D},
      '{ACT_I, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_I, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_I, ACT_P, ACT_C, ACT_P, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_I},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_I, ACT_I},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_I},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_I, ACT_I, ACT_I,
        ACT_I, ACT_D},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_I, ACT_I},
      '{ACT_D, ACT_P, ACT_I, ACT_I, ACT_I, ACT_P, ACT_P, ACT_P, ACT_D, ACT_I, ACT_D, ACT_D,
        ACT_D, ACT_I, ACT_I, ACT_I, ACT_D, ACT_D, ACT_P, ACT_C, ACT_P, ACT_D, ACT_D, ACT_D,
        ACT_D, ACT_I}
   };

endpackage

`default_nettype wire

// ===== rtl/ptlb_if.sv =====
// ----------------------------------------------------------------------------
// ptlb_req_if / ptlb_rsp_if
// Valid/ready channels for character requests and break results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptlb_req_if;
   logic                     valid;
   logic                     ready;
   ptlb_pkg::code_point_type code_point;
   logic [5:0]               break_type;
   logic                     first_of_text;

   modport source (output valid, output code_point, output break_type,
                   output first_of_text, input ready);
   modport sink (input valid, input code_point, input break_type,
                 input first_of_text, output ready);
endinterface

interface ptlb_rsp_if;
   logic                valid;
   logic                ready;
   logic                break_before;
   logic                forced;
   ptlb_pkg::class_type char_class;

   modport source (output valid, output break_before, output forced,
                   output char_class, input ready);
   modport sink (input valid, input break_before, input forced,
                 input char_class, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptlb_classify.sv =====
// ----------------------------------------------------------------------------
// ptlb_classify
// Reduces the raw line break property to a table class and applies the
// code points that always act as mandatory breaks.
// ----------------------------------------------------------------------------
`default_nettype none

module ptlb_classify (
   input  wire ptlb_pkg::code_point_type code_point,
   input  wire logic [5:0]               break_type,
   output ptlb_pkg::class_type           char_class
);

   ptlb_pkg::class_type reduced;

   always_comb begin
      if (break_type < 6'(ptlb_pkg::RawClasses)) begin
         reduced = ptlb_pkg::REDUCED_CLASS[break_type];
      end else begin
         reduced = ptlb_pkg::CLS_AL;
      end
   end

   assign char_class = (code_point == ptlb_pkg::CP_LINE_FEED ||
                        code_point == ptlb_pkg::CP_LINE_SEPARATOR ||
                        code_point == ptlb_pkg::CP_PARA_SEPARATOR) ?
                       ptlb_pkg::CLS_BK : reduced;

endmodule

`default_nettype wire

// ===== rtl/ptlb_step.sv =====
// ----------------------------------------------------------------------------
// ptlb_step
// Segment state and the pair table decision for one character per cycle while advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ptlb_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire ptlb_pkg::class_type    char_class,
   input  wire logic                   first_of_text,
   output ptlb_pkg::rsp_item_type      result
);

   logic                segment_open_ff, segment_open_in;
   logic                hard_pending_ff, hard_pending_in;
   ptlb_pkg::class_type base_class_ff, base_class_in;
   ptlb_pkg::class_type previous_class_ff, previous_class_in;

   ptlb_pkg::class_type     open_class;
   ptlb_pkg::table_index_type row;
   ptlb_pkg::table_index_type col;
   ptlb_pkg::action_type    action;
   logic                    after_space;

   assign open_class  = (char_class == ptlb_pkg::CLS_SP) ? ptlb_pkg::CLS_WJ : char_class;
   assign after_space = (previous_class_ff == ptlb_pkg::CLS_SP);
   assign row = (base_class_ff < 6'(ptlb_pkg::TableClasses)) ?
                base_class_ff[4:0] : ptlb_pkg::CLS_AL[4:0];
   assign col = (char_class < 6'(ptlb_pkg::TableClasses)) ? char_class[4:0] : '0;
   assign action = ptlb_pkg::PAIR_TABLE[row][col];

   always_comb begin
      segment_open_in     = segment_open_ff;
      hard_pending_in     = hard_pending_ff;
      base_class_in       = base_class_ff;
      previous_class_in   = previous_class_ff;
      result.break_before = 1'b0;
      result.forced       = 1'b0;
      result.char_class   = char_class;
      if (first_of_text || !segment_open_ff || hard_pending_ff) begin
         // A segment starts here; after a mandatory break it is a forced break.
         result.break_before = segment_open_ff && !first_of_text;
         result.forced       = segment_open_ff && !first_of_text;
         result.char_class   = open_class;
         segment_open_in     = 1'b1;
         hard_pending_in     = (open_class == ptlb_pkg::CLS_BK);
         base_class_in       = open_class;
         previous_class_in   = open_class;
      end else if (char_class == ptlb_pkg::CLS_BK) begin
         hard_pending_in   = 1'b1;
         previous_class_in = char_class;
      end else if (char_class == ptlb_pkg::CLS_SP) begin
         previous_class_in = char_class;
      end else begin
         previous_class_in = char_class;
         case (action)
            ptlb_pkg::ACT_D: begin
               result.break_before = 1'b1;
               base_class_in       = char_class;
            end
            ptlb_pkg::ACT_I: begin
               result.break_before = after_space;
               base_class_in       = char_class;
            end
            ptlb_pkg::ACT_P: begin
               base_class_in = char_class;
            end
            ptlb_pkg::ACT_C: begin
               if (after_space) begin
                  result.break_before = 1'b1;
                  base_class_in       = char_class;
               end
            end
            default: begin
               if (after_space) begin
                  base_class_in = char_class;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_open_ff   <= 1'b0;
         hard_pending_ff   <= 1'b0;
         base_class_ff     <= '0;
         previous_class_ff <= '0;
      end else if (advance) begin
         segment_open_ff   <= segment_open_in;
         hard_pending_ff   <= hard_pending_in;
         base_class_ff     <= base_class_in;
         previous_class_ff <= previous_class_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pair_table_line_breaker_unit.sv =====
// ----------------------------------------------------------------------------
// pair_table_line_breaker_unit
// Reports line break opportunities for a stream of decoded characters.
// ----------------------------------------------------------------------------
// Each request carries one character with its raw line break property and a
// start-of-text flag, and yields exactly one response telling whether a break
// opportunity lies before that character, whether it is forced by a preceding
// mandatory break character (a line feed, a line or paragraph separator, or a
// character whose property is mandatory break), and the reduced class given to
// it. A request is captured in an input register and its response is moved
// into the output register when that is empty or being read; one request is
// taken every cycle while responses are accepted, limited by the single pass
// through the class map and the pair table that updates the segment state.
`default_nettype none

module pair_table_line_breaker_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   ptlb_req_if.sink    req,
   ptlb_rsp_if.source  rsp
);

   logic                   in_valid_ff, in_valid_in;
   ptlb_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   ptlb_pkg::rsp_item_type out_item_ff;

   logic                   advance;
   logic                   req_fire;
   ptlb_pkg::class_type    char_class;
   ptlb_pkg::rsp_item_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   ptlb_classify u_classify (
      .code_point (in_item_ff.code_point),
      .break_type (in_item_ff.break_type),
      .char_class (char_class)
   );

   ptlb_step u_step (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .char_class    (char_class),
      .first_of_text (in_item_ff.first_of_text),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.code_point    <= req.code_point;
         in_item_ff.break_type    <= req.break_type;
         in_item_ff.first_of_text <= req.first_of_text;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.break_before = out_item_ff.break_before;
   assign rsp.forced       = out_item_ff.forced;
   assign rsp.char_class   = out_item_ff.char_class;

endmodule

`default_nettype wire
